// File: src/pbrd_pkg.sv
// Shared types and constants of the PackBits row decoder.
package pbrd_pkg;

    localparam int ByteW         = 8;
    localparam int RowW          = 11;
    localparam int CntW          = 3;
    localparam int RunW          = 8;
    localparam int ChunkBytes    = 4;
    localparam int QueueDepth    = 2;
    localparam int QueuePtrW     = 1;
    localparam int QueueCntW     = 2;

    localparam logic [RowW-1:0]  ResetRowBytes = 11'd40;
    localparam logic [ByteW-1:0] CtrlNoOp      = 8'd128;

    // One decoded run handed from the front end to the unpacker.
    typedef struct packed {
        logic [ByteW-1:0] value;
        logic [RunW-1:0]  count;
        logic             row_end;
        logic             overshoot;
    } cmd_t;

endpackage

// File: src/pbrd_if.sv
// Channel interfaces: compressed input stream, packed results and row length writes.
interface pbrd_in_if;
    import pbrd_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pbrd_out_if;
    import pbrd_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic [ByteW-1:0] byte2;
    logic [ByteW-1:0] byte3;
    logic [CntW-1:0]  byte_count;
    logic             run_last;
    logic             row_end;
    logic             overshoot;

    modport source (output valid, output byte0, output byte1, output byte2,
                    output byte3, output byte_count, output run_last,
                    output row_end, output overshoot, input ready);
    modport sink   (input valid, input byte0, input byte1, input byte2,
                    input byte3, input byte_count, input run_last,
                    input row_end, input overshoot, output ready);
endinterface

interface pbrd_cfg_if;
    import pbrd_pkg::*;
    logic            valid;
    logic            ready;
    logic [RowW-1:0] row_bytes;

    modport source (output valid, output row_bytes, input ready);
    modport sink   (input valid, input row_bytes, output ready);
endinterface

// File: src/pbrd_front.sv
// Front end: parses control bytes, tracks the row position and issues run requests.
module pbrd_front #(
    parameter int MAX_ROW_BYTES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    pbrd_in_if.sink         stream,
    pbrd_cfg_if.sink        cfg,
    input  logic            q_full,
    output logic            q_push,
    output pbrd_pkg::cmd_t  q_data
);
    import pbrd_pkg::*;

    // The register is 11 bits wide, so a larger limit clamps to 2047.
    localparam int MaxClamp = (MAX_ROW_BYTES > 2047) ? 2047 : MAX_ROW_BYTES;
    localparam logic [RowW-1:0] MaxRow = RowW'(MaxClamp);

    typedef enum logic [1:0] {PH_CTRL, PH_LIT, PH_REP} phase_t;

    function automatic logic [RowW-1:0] eff_row(input logic [RowW-1:0] r);
        logic [RowW-1:0] v;
        v = r;
        if (v == '0) v = RowW'(1);
        if (v > MaxRow) v = MaxRow;
        return v;
    endfunction

    phase_t           phase_reg, phase_next;
    logic [RunW-1:0]  literal_left_reg, literal_left_next;
    logic [RunW-1:0]  repeat_count_reg, repeat_count_next;
    logic [RowW-1:0]  row_left_reg, row_left_next;
    logic             overrun_reg, overrun_next;
    logic [RowW-1:0]  row_bytes_reg;

    logic             accept;
    logic [RowW-1:0]  eff;
    logic [RunW-1:0]  rest;
    logic [RowW-1:0]  row_dec;
    logic [RowW-1:0]  rl;
    logic [RowW-1:0]  total;
    logic [RowW-1:0]  emit;
    logic             rend;
    logic             over;

    assign stream.ready = !q_full;
    assign cfg.ready    = 1'b1;
    assign accept       = stream.valid && stream.ready;
    assign eff          = eff_row(row_bytes_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        literal_left_next = literal_left_reg;
        repeat_count_next = repeat_count_reg;
        row_left_next     = row_left_reg;
        overrun_next      = overrun_reg;
        q_push            = 1'b0;
        q_data            = '0;
        rest              = (literal_left_reg != '0) ? literal_left_reg - RunW'(1) : '0;
        row_dec           = (row_left_reg != '0) ? row_left_reg - RowW'(1) : '0;
        rl                = (row_left_reg == '0) ? eff : row_left_reg;
        total             = RowW'(repeat_count_reg);
        emit              = (total > rl) ? rl : total;
        rend              = 1'b0;
        over              = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_LIT:
                begin
                    if (!overrun_reg)
                    begin
                        rend          = (row_dec == '0);
                        over          = rend && (rest != '0);
                        row_left_next = rend ? eff : row_dec;
                        overrun_next  = over;
                        q_push        = 1'b1;
                        q_data        = '{value: stream.data_byte, count: RunW'(1),
                                          row_end: rend, overshoot: over};
                    end
                    literal_left_next = rest;
                    if (rest == '0)
                    begin
                        phase_next   = PH_CTRL;
                        overrun_next = 1'b0;
                    end
                end
                PH_REP:
                begin
                    rend              = (emit == rl);
                    over              = (total > rl);
                    row_left_next     = rend ? eff : rl - emit;
                    q_push            = 1'b1;
                    q_data            = '{value: stream.data_byte, count: emit[RunW-1:0],
                                          row_end: rend, overshoot: rend && over};
                    repeat_count_next = '0;
                    phase_next        = PH_CTRL;
                    overrun_next      = 1'b0;
                end
                default:
                begin
                    phase_next = PH_CTRL;
                    if (stream.data_byte < CtrlNoOp)
                    begin
                        literal_left_next = stream.data_byte + RunW'(1);
                        phase_next        = PH_LIT;
                    end
                    else if (stream.data_byte > CtrlNoOp)
                    begin
                        // 257 - n taken modulo 256 gives the repeat length 2..128.
                        repeat_count_next = RunW'(1) - stream.data_byte;
                        phase_next        = PH_REP;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_CTRL;
            literal_left_reg <= '0;
            repeat_count_reg <= '0;
            row_left_reg     <= eff_row(ResetRowBytes);
            overrun_reg      <= 1'b0;
            row_bytes_reg    <= ResetRowBytes;
        end
        else if (cfg.valid && cfg.ready)
        begin
            phase_reg        <= PH_CTRL;
            literal_left_reg <= '0;
            repeat_count_reg <= '0;
            row_left_reg     <= eff_row(cfg.row_bytes);
            overrun_reg      <= 1'b0;
            row_bytes_reg    <= cfg.row_bytes;
        end
        else
        begin
            phase_reg        <= phase_next;
            literal_left_reg <= literal_left_next;
            repeat_count_reg <= repeat_count_next;
            row_left_reg     <= row_left_next;
            overrun_reg      <= overrun_next;
        end
    end

endmodule

// File: src/pbrd_queue.sv
// Two-entry queue of run requests between the front end and the unpacker.
module pbrd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pbrd_pkg::cmd_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output pbrd_pkg::cmd_t head
);
    import pbrd_pkg::*;

    cmd_t                 entry_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueueCntW-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == QueueCntW'(QueueDepth));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QueuePtrW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QueuePtrW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QueueCntW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QueueCntW'(1);
            end
        end
    end

endmodule

// File: src/pbrd_back.sv
// Unpacker: splits each run request into results of up to four bytes.
module pbrd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  pbrd_pkg::cmd_t q_head,
    output logic           q_pop,
    pbrd_out_if.source     result
);
    import pbrd_pkg::*;

    logic [RunW-1:0]  done_reg;
    logic [RunW-1:0]  left;
    logic [CntW-1:0]  chunk;
    logic             last;
    logic             load;

    logic             valid_reg;
    logic [ByteW-1:0] byte0_reg, byte1_reg, byte2_reg, byte3_reg;
    logic [CntW-1:0]  count_reg;
    logic             last_reg, row_end_reg, over_reg;

    assign left  = q_head.count - done_reg;
    assign last  = (left <= RunW'(ChunkBytes));
    assign chunk = last ? left[CntW-1:0] : CntW'(ChunkBytes);
    assign load  = !q_empty && (!valid_reg || result.ready);
    assign q_pop = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                done_reg  <= last ? '0 : done_reg + RunW'(ChunkBytes);
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte0_reg   <= (chunk > CntW'(0)) ? q_head.value : '0;
            byte1_reg   <= (chunk > CntW'(1)) ? q_head.value : '0;
            byte2_reg   <= (chunk > CntW'(2)) ? q_head.value : '0;
            byte3_reg   <= (chunk > CntW'(3)) ? q_head.value : '0;
            count_reg   <= chunk;
            last_reg    <= last;
            row_end_reg <= last && q_head.row_end;
            over_reg    <= last && q_head.overshoot;
        end
    end

    assign result.valid      = valid_reg;
    assign result.byte0      = byte0_reg;
    assign result.byte1      = byte1_reg;
    assign result.byte2      = byte2_reg;
    assign result.byte3      = byte3_reg;
    assign result.byte_count = count_reg;
    assign result.run_last   = last_reg;
    assign result.row_end    = row_end_reg;
    assign result.overshoot  = over_reg;

endmodule

// File: src/packbits_row_decoder.sv
// Top level of the PackBits row decoder: front end, request queue and unpacker.
// A literal or repeat byte is registered in the request queue, then in the output stage.
// Throughput: one compressed byte per cycle while the queue has room; a repeat run of n
// bytes holds the unpacker for ceil(n/4) results (up to 32), which sets the sustained rate.
// Reset: all control state clears, the row length returns to 40 bytes and the
// decoder waits for a control byte; the queue and the output stage come up empty.
module packbits_row_decoder #(
    parameter int MAX_ROW_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    pbrd_in_if.sink     stream,
    pbrd_cfg_if.sink    cfg,
    pbrd_out_if.source  result
);
    import pbrd_pkg::*;

    // Each request from the front end describes one run that produces results:
    // the byte value, how many of its bytes fit in the row, and the row end flags.
    cmd_t q_data;
    cmd_t q_head;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // The front end consumes every compressed byte. Control bytes and literal
    // bytes dropped past the row end make no request; it stalls only when the
    // queue is full.
    pbrd_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    // The queue lets the front end keep parsing while a long repeat run drains.
    pbrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // The unpacker emits up to four bytes a cycle, while its output stage is free or being
    // taken, into a registered output stage, so a waiting result never blocks the queue from filling.
    pbrd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// File: src/pbrd_checker.sv
// Port-level checks on the decoder's results, bound to the top level.
module pbrd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] byte0,
    input logic [7:0] byte1,
    input logic [7:0] byte2,
    input logic [7:0] byte3,
    input logic [2:0] byte_count,
    input logic       run_last,
    input logic       row_end,
    input logic       overshoot
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(byte0) && $stable(byte_count)
            && $stable(row_end) && $stable(overshoot))
        else $error("result changed while stalled");

    // Every result carries one to four bytes.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> byte_count != 3'd0 && byte_count <= 3'd4)
        else $error("result byte count out of range");

    // A row can only end on the last result of a run.
    a_rowend: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && row_end |-> run_last)
        else $error("row end inside a run");

    // Overshoot is reported only where the row ends.
    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overshoot |-> row_end)
        else $error("overshoot without row end");

    // Unused byte lanes read as zero when a result carries one byte.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && byte_count == 3'd1 |-> byte1 == 8'd0 && byte2 == 8'd0
            && byte3 == 8'd0)
        else $error("unused byte lane not zero");

endmodule

bind packbits_row_decoder pbrd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .byte0      (result.byte0),
    .byte1      (result.byte1),
    .byte2      (result.byte2),
    .byte3      (result.byte3),
    .byte_count (result.byte_count),
    .run_last   (result.run_last),
    .row_end    (result.row_end),
    .overshoot  (result.overshoot)
);

// File: bench/pbrd_row_checker.sv
// Result checker for the PackBits row decoder: predicts packed results and compares them.
module pbrd_row_checker #(
    parameter int MaxRow = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    pbrd_in_if          stream,
    pbrd_cfg_if         cfg,
    pbrd_out_if         result,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pbrd_pkg::*;

    typedef enum logic [1:0] {ExpectCtrl, InLiteral, InRepeat} dec_phase_e;

    typedef struct packed {
        logic [3:0][ByteW-1:0] bytes;
        logic [CntW-1:0]       count;
        logic                  run_last;
        logic                  row_end;
        logic                  overshoot;
    } word_t;

    word_t           decoded_q [$];
    dec_phase_e      phase_q;
    logic [RowW-1:0] row_len;
    logic [RowW-1:0] row_left;
    logic [RunW-1:0] lit_left;
    logic [RunW-1:0] rep_count;
    logic            overrun;
    int unsigned     words_seen;

    function automatic logic [RowW-1:0] clamp_row(logic [RowW-1:0] r);
        if (r == '0) return RowW'(1);
        if (r > RowW'(MaxRow)) return RowW'(MaxRow);
        return r;
    endfunction

    // A write of the row length restarts decoding from a fresh row.
    task automatic restart(logic [RowW-1:0] len);
        row_len   = len;
        phase_q   = ExpectCtrl;
        lit_left  = '0;
        rep_count = '0;
        row_left  = clamp_row(len);
        overrun   = 1'b0;
    endtask

    task automatic push_word(logic [ByteW-1:0] d, int unsigned cnt, logic is_last,
                             logic rend, logic ovr);
        word_t w;
        for (int j = 0; j < 4; j++)
            w.bytes[j] = (j < cnt) ? d : '0;
        w.count     = CntW'(cnt);
        w.run_last  = is_last;
        w.row_end   = rend;
        w.overshoot = ovr;
        decoded_q.push_back(w);
    endtask

    task automatic decode_byte(logic [ByteW-1:0] d);
        logic [RunW-1:0] rest;
        logic            rend;
        logic            ovr;
        logic            is_last;
        int unsigned     total;
        int unsigned     emit;
        int unsigned     c;
        case (phase_q)
            InLiteral:
            begin
                rest = (lit_left != '0) ? lit_left - RunW'(1) : '0;
                if (!overrun)
                begin
                    if (row_left != '0) row_left = row_left - RowW'(1);
                    rend = (row_left == '0);
                    ovr  = 1'b0;
                    if (rend)
                    begin
                        ovr      = (rest != '0);
                        row_left = clamp_row(row_len);
                        if (ovr) overrun = 1'b1;
                    end
                    push_word(d, 1, 1'b1, rend, ovr);
                end
                lit_left = rest;
                if (lit_left == '0)
                begin
                    phase_q = ExpectCtrl;
                    overrun = 1'b0;
                end
            end
            InRepeat:
            begin
                total = rep_count;
                if (row_left == '0) row_left = clamp_row(row_len);
                emit = total;
                if (emit > row_left) emit = row_left;
                rend     = (emit == row_left);
                ovr      = (total > row_left);
                row_left = row_left - RowW'(emit);
                while (emit > 0)
                begin
                    c       = (emit > 4) ? 4 : emit;
                    emit    = emit - c;
                    is_last = (emit == 0);
                    push_word(d, c, is_last, is_last && rend, is_last && rend && ovr);
                end
                if (rend) row_left = clamp_row(row_len);
                rep_count = '0;
                phase_q   = ExpectCtrl;
                overrun   = 1'b0;
            end
            default:
            begin
                phase_q = ExpectCtrl;
                if (d < CtrlNoOp)
                begin
                    lit_left = d + RunW'(1);
                    phase_q  = InLiteral;
                end
                else if (d > CtrlNoOp)
                begin
                    rep_count = RunW'(257 - int'(d));
                    phase_q   = InRepeat;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (fail_count < 100)
            $display("[%0t] result %0d: %s is %0h, expected %0h",
                     $realtime, words_seen, what, got, want);
        fail_count++;
    endtask

    task automatic check_word();
        word_t                 w;
        logic [3:0][ByteW-1:0] got;
        got = {result.byte3, result.byte2, result.byte1, result.byte0};
        if (decoded_q.size() == 0)
        begin
            report_mismatch("unexpected result, byte0", result.byte0, 0);
        end
        else
        begin
            w = decoded_q.pop_front();
            for (int j = 0; j < 4; j++)
                if (got[j] !== w.bytes[j])
                    report_mismatch($sformatf("byte%0d", j), got[j], w.bytes[j]);
            if (result.byte_count !== w.count)
                report_mismatch("byte_count", result.byte_count, w.count);
            if (result.run_last !== w.run_last)
                report_mismatch("run_last", result.run_last, w.run_last);
            if (result.row_end !== w.row_end)
                report_mismatch("row_end", result.row_end, w.row_end);
            if (result.overshoot !== w.overshoot)
                report_mismatch("overshoot", result.overshoot, w.overshoot);
        end
        words_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart(ResetRowBytes);
            decoded_q.delete();
            words_seen = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                restart(cfg.row_bytes);
            if (stream.valid && stream.ready)
                decode_byte(stream.data_byte);
            if (result.valid && result.ready)
                check_word();
            pending = decoded_q.size();
        end
    end

endmodule

// File: bench/tb_packbits_row_decoder.sv
// Testbench top for the PackBits row decoder: clock, reset, stimulus and the verdict.
module tb_packbits_row_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import pbrd_pkg::*;

    localparam int MaxRow       = 1024;
    localparam int SegItems     = 40;
    localparam int Segments     = 12;
    // Items that cause no result never enter the decoder's queue and are not
    // counted as pending, so a settle wait follows the last expected result
    // before the row length is rewritten.
    localparam int SettleCycles = 8;
    localparam int DrainCycles  = 40;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned n_fail;
    int unsigned n_pending;
    int unsigned send_idle;
    int unsigned recv_idle;

    pbrd_in_if  stream_if ();
    pbrd_cfg_if cfg_if ();
    pbrd_out_if result_if ();

    packbits_row_decoder #(
        .MAX_ROW_BYTES(MaxRow)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(stream_if),
        .cfg   (cfg_if),
        .result(result_if)
    );

    pbrd_row_checker #(
        .MaxRow(MaxRow)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .cfg       (cfg_if),
        .result    (result_if),
        .fail_count(n_fail),
        .pending   (n_pending)
    );

    always #10 clk = ~clk;

    // The result side stalls at random, at the rate of the current phase.
    always @(negedge clk)
        result_if.ready <= ($urandom_range(99) >= recv_idle);

    // Hard stop in case the decoder hangs.
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Offers one compressed byte as a request and holds it until accepted.
    // Valid is left high; the next call replaces or lowers it, or a settle lowers it.
    task automatic send_byte(logic [ByteW-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= b;
        do @(posedge clk); while (!stream_if.ready);
    endtask

    // Waits until every predicted result has been taken and the decoder
    // has had time to swallow any trailing control or dropped bytes.
    task automatic settle();
        @(negedge clk);
        stream_if.valid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_row_len(logic [RowW-1:0] len);
        @(negedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.row_bytes <= len;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Random stream, mostly well-formed runs with random content. Literal
    // runs are usually short with an occasional long one; repeat runs favor
    // short counts but reach the full 128. A few no-op controls and stray
    // bytes knock the decoder out of step now and then.
    task automatic run_segment(int unsigned n);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
                send_byte(ByteW'(len));
                repeat (len + 1) send_byte(ByteW'($urandom_range(255)));
                sent += len + 2;
            end
            else if (pick < 85)
            begin
                if ($urandom_range(3) == 0)
                    send_byte(ByteW'($urandom_range(255, 129)));
                else
                    send_byte(ByteW'($urandom_range(255, 240)));
                send_byte(ByteW'($urandom_range(255)));
                sent += 2;
            end
            else if (pick < 90)
            begin
                send_byte(CtrlNoOp);
                sent += 1;
            end
            else
            begin
                send_byte(ByteW'($urandom_range(255)));
                sent += 1;
            end
        end
    endtask

    initial
    begin
        // Under the reset row length of 40: zero control, both byte extremes,
        // the no-op control, the shortest and longest repeats (the longest
        // runs past the row end), and a short literal.
        logic [ByteW-1:0] intro [$] = '{8'h00, 8'h00, CtrlNoOp, 8'h00, 8'hFF,
                                        8'hFF, 8'hA5, 8'h81, 8'h5A, 8'h82, 8'h00,
                                        8'h01, 8'h12, 8'h34, 8'hFF, 8'hC3};
        // Under a one-byte row: a literal past the row end with its tail
        // dropped, then a repeat clipped at the row end.
        logic [ByteW-1:0] tail [$] = '{8'h02, 8'h11, 8'h22, 8'h33, 8'hFD, 8'h77};
        // Row lengths per random segment, including zero (acts as one),
        // the largest legal value and values past it.
        logic [RowW-1:0] row_table [Segments] = '{11'd0, 11'd1, 11'd2047, 11'd3,
                                                  11'd1024, 11'd5, 11'd40, 11'd4,
                                                  11'd1025, 11'd7, 11'd2, 11'd17};

        stream_if.valid     = 1'b0;
        stream_if.data_byte = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.row_bytes    = '0;
        result_if.ready     = 1'b0;
        send_idle           = 35;
        recv_idle           = 85;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (intro[i]) send_byte(intro[i]);
        settle();
        write_row_len(RowW'(1));
        foreach (tail[i]) send_byte(tail[i]);

        // Four segments per idling phase: receiver-heavy stalls, then
        // sender-heavy gaps, then full speed on both sides.
        for (int seg = 0; seg < Segments; seg++)
        begin
            if (seg == 4)
            begin
                send_idle = 85;
                recv_idle = 35;
            end
            else if (seg == 8)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            settle();
            write_row_len(row_table[seg]);
            run_segment(SegItems);
            // Sometimes leave a literal run half done so that the next
            // row length write has to abandon it.
            if ($urandom_range(1) == 1)
            begin
                send_byte(ByteW'(5));
                send_byte(ByteW'($urandom_range(255)));
                send_byte(ByteW'($urandom_range(255)));
            end
        end

        settle();
        repeat (DrainCycles) @(posedge clk);
        if (n_fail == 0 && n_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
